// File: src/jspu_pkg.sv
package jspu_pkg;

  // field widths
  localparam int unsigned VAL_W      = 40;
  localparam int unsigned ABS_W      = 39;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned DIAG_W     = 48;
  localparam int unsigned INV_W      = 40;
  localparam int unsigned STEP_W     = 39;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;

  // grid size defaults
  localparam int unsigned GRID_X_DEFAULT = 64;
  localparam int unsigned GRID_Y_DEFAULT = 64;
  localparam int unsigned GRID_Z_DEFAULT = 64;

  // register stages from input word to output register
  localparam int unsigned PIPE_DEPTH = 10;

  // register reset values
  localparam logic [COEF_W-1:0] COEF_A_RST = 32'd256000000;
  localparam logic [DIAG_W-1:0] DIAG_RST   = 48'd279810000;
  localparam logic [INV_W-1:0]  INV_H2_RST = 40'd65028096;
  localparam logic [STEP_W-1:0] STEP_RST   = 39'd136348168;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A     = 4'd0,
    REG_DIAG_RECIP = 4'd1,
    REG_INV_HX2    = 4'd2,
    REG_INV_HY2    = 4'd3,
    REG_INV_HZ2    = 4'd4,
    REG_STEP_X     = 4'd5,
    REG_STEP_Y     = 4'd6,
    REG_STEP_Z     = 4'd7
  } jspu_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] coef_a;
    logic [DIAG_W-1:0] diag_recip;
    logic [INV_W-1:0]  inv_hx2;
    logic [INV_W-1:0]  inv_hy2;
    logic [INV_W-1:0]  inv_hz2;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [STEP_W-1:0] step_z;
  } jspu_cfg_t;

endpackage

// File: src/jspu_datapath.sv
module jspu_datapath import jspu_pkg::*; #(
  parameter int unsigned GRID_X = GRID_X_DEFAULT,
  parameter int unsigned GRID_Y = GRID_Y_DEFAULT,
  parameter int unsigned GRID_Z = GRID_Z_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  jspu_cfg_t               cfg_i,
  input  logic signed [VAL_W-1:0] center_value_i,
  input  logic signed [VAL_W-1:0] west_value_i,
  input  logic signed [VAL_W-1:0] east_value_i,
  input  logic signed [VAL_W-1:0] south_value_i,
  input  logic signed [VAL_W-1:0] north_value_i,
  input  logic signed [VAL_W-1:0] below_value_i,
  input  logic signed [VAL_W-1:0] above_value_i,
  input  logic [IDX_W-1:0]        x_index_i,
  input  logic [IDX_W-1:0]        y_index_i,
  input  logic [IDX_W-1:0]        z_index_i,
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] new_value_o,
  output logic [ABS_W-1:0]        abs_change_o,
  output logic                    on_boundary_o
);

  // fraction shifts
  localparam int unsigned SQ_SHR = 32;
  localparam int unsigned AX_SHR = 16;
  localparam int unsigned A_SHR  = 8;
  localparam int unsigned D_SHR  = 48;

  localparam int unsigned TERM_W = 61;                 // capped terms, up to 2^60
  localparam logic [63:0] TERM_CAP = 64'd1 << 60;

  // coordinate magnitude and its square split
  localparam int unsigned SQM_W = IDX_W + STEP_W;
  localparam int unsigned SQL_W = (SQM_W + 1) / 2;
  localparam int unsigned SQH_W = SQM_W - SQL_W;
  localparam int unsigned SQF_W = 2 * SQM_W;

  // neighbour pair magnitude and inverse step split
  localparam int unsigned PS_W  = VAL_W + 1;
  localparam int unsigned PL_W  = PS_W / 2;
  localparam int unsigned PH_W  = PS_W - PL_W;
  localparam int unsigned IL_W  = INV_W / 2;
  localparam int unsigned IH_W  = INV_W - IL_W;
  localparam int unsigned AXF_W = PS_W + INV_W;
  localparam int unsigned AT_W  = TERM_W + 1;

  // radius sum and a term
  localparam int unsigned R2_W = TERM_W + 1;
  localparam int unsigned RL_W = R2_W / 2;
  localparam int unsigned RH_W = R2_W - RL_W;
  localparam int unsigned AF_W = COEF_W + R2_W;

  // total and final scaling
  localparam int unsigned TOT_W = 64;
  localparam int unsigned MAG_W = TOT_W - 1;
  localparam int unsigned ML_W  = 32;
  localparam int unsigned MH_W  = MAG_W - ML_W;
  localparam int unsigned DL_W  = DIAG_W / 2;
  localparam int unsigned DH_W  = DIAG_W - DL_W;
  localparam int unsigned FF_W  = MAG_W + DIAG_W;
  localparam int unsigned R_W   = FF_W - D_SHR;

  localparam logic signed [SQM_W:0] ONE_Q32 = {{(SQM_W - SQ_SHR){1'b0}}, 1'b1, {SQ_SHR{1'b0}}};
  localparam logic signed [TOT_W-1:0] SIX_Q32 = 64'sd6 <<< 32;

  localparam logic [IDX_W:0] LIM_X = (IDX_W + 1)'(GRID_X - 1);
  localparam logic [IDX_W:0] LIM_Y = (IDX_W + 1)'(GRID_Y - 1);
  localparam logic [IDX_W:0] LIM_Z = (IDX_W + 1)'(GRID_Z - 1);

  localparam logic [R_W-1:0]   POS_LIM = R_W'({(VAL_W - 1){1'b1}});
  localparam logic [R_W-1:0]   NEG_LIM = R_W'({1'b1, {(VAL_W - 1){1'b0}}});
  localparam logic [VAL_W-1:0] NV_MAX  = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0] NV_MIN  = {1'b1, {(VAL_W - 1){1'b0}}};

  // per-axis views of the input word and config
  logic [IDX_W-1:0]        idx     [3];
  logic [STEP_W-1:0]       stp     [3];
  logic [INV_W-1:0]        inv     [3];
  logic signed [VAL_W-1:0] nb_lo   [3];
  logic signed [VAL_W-1:0] nb_hi   [3];
  logic [SQM_W-1:0]        cprod   [3];
  logic signed [SQM_W:0]   coord   [3];
  logic signed [SQM_W:0]   coord_n [3];
  logic [PS_W-1:0]         psum    [3];
  logic                    bnd_d;

  // stage 1
  logic [SQM_W-1:0] s1_sqm_q [3];
  logic [PS_W-1:0]  s1_pm_q  [3];
  logic             s1_pn_q  [3];
  // stage 2
  logic [2*SQH_W-1:0]      s2_sq_hh_q [3];
  logic [SQH_W+SQL_W-1:0]  s2_sq_hl_q [3];
  logic [2*SQL_W-1:0]      s2_sq_ll_q [3];
  logic [PH_W+IH_W-1:0]    s2_ax_hh_q [3];
  logic [PH_W+IL_W-1:0]    s2_ax_hl_q [3];
  logic [PL_W+IH_W-1:0]    s2_ax_lh_q [3];
  logic [PL_W+IL_W-1:0]    s2_ax_ll_q [3];
  logic                    s2_pn_q    [3];
  // stage 3
  logic [SQF_W-1:0]        sq_full [3];
  logic [SQF_W-SQ_SHR-1:0] sq_shr  [3];
  logic [AXF_W-1:0]        ax_full [3];
  logic [AXF_W-AX_SHR-1:0] ax_shr  [3];
  logic [TERM_W-1:0]       ax_sat  [3];
  logic [TERM_W-1:0]       s3_sq_q [3];
  logic signed [AT_W-1:0]  s3_at_q [3];
  // stage 4 .. 9
  logic [R2_W-1:0]          s4_r2_q;
  logic signed [TOT_W-1:0]  s4_ax_q;
  logic [COEF_W+RL_W-1:0]   s5_alo_q;
  logic [COEF_W+RH_W-1:0]   s5_ahi_q;
  logic signed [TOT_W-1:0]  s5_ax_q;
  logic [AF_W-1:0]          a_full;
  logic [AF_W-A_SHR-1:0]    a_shr;
  logic [TERM_W-1:0]        s6_a_q;
  logic signed [TOT_W-1:0]  s6_ax_q;
  logic signed [TOT_W-1:0]  total;
  logic signed [TOT_W-1:0]  total_n;
  logic [MAG_W-1:0]         s7_mag_q;
  logic                     s7_neg_q;
  logic [MH_W+DH_W-1:0]     s8_hh_q;
  logic [MH_W+DL_W-1:0]     s8_hl_q;
  logic [ML_W+DH_W-1:0]     s8_lh_q;
  logic [ML_W+DL_W-1:0]     s8_ll_q;
  logic                     s8_neg_q;
  logic [FF_W-1:0]          f_full;
  logic [R_W-1:0]           f_r;
  logic [VAL_W-1:0]         nv_d;
  logic [VAL_W-1:0]         s9_nv_q;
  // output stage
  logic [VAL_W:0]           diff;
  logic [VAL_W:0]           diff_m;
  logic signed [VAL_W-1:0]  new_value_d;
  logic [ABS_W-1:0]         abs_change_d;

  // valid, boundary flag and center travel alongside
  logic                     valid_q [PIPE_DEPTH];
  logic                     bnd_q   [PIPE_DEPTH-1];
  logic [VAL_W-1:0]         ctr_q   [PIPE_DEPTH-1];
  logic signed [VAL_W-1:0]  new_value_q;
  logic [ABS_W-1:0]         abs_change_q;
  logic                     on_boundary_q;

  always_comb begin
    idx[0] = x_index_i;  idx[1] = y_index_i;  idx[2] = z_index_i;
    stp[0] = cfg_i.step_x;  stp[1] = cfg_i.step_y;  stp[2] = cfg_i.step_z;
    inv[0] = cfg_i.inv_hx2; inv[1] = cfg_i.inv_hy2; inv[2] = cfg_i.inv_hz2;
    nb_lo[0] = west_value_i;  nb_hi[0] = east_value_i;
    nb_lo[1] = south_value_i; nb_hi[1] = north_value_i;
    nb_lo[2] = below_value_i; nb_hi[2] = above_value_i;
  end

  // stage 1: coordinates and pair sums
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cprod[a]   = SQM_W'(idx[a]) * SQM_W'(stp[a]);
      coord[a]   = $signed({1'b0, cprod[a]}) - ONE_Q32;
      coord_n[a] = -coord[a];
      psum[a]    = {nb_lo[a][VAL_W-1], nb_lo[a]} + {nb_hi[a][VAL_W-1], nb_hi[a]};
    end
    bnd_d = (x_index_i == '0) || ({1'b0, x_index_i} >= LIM_X) ||
            (y_index_i == '0) || ({1'b0, y_index_i} >= LIM_Y) ||
            (z_index_i == '0) || ({1'b0, z_index_i} >= LIM_Z);
  end

  // stage 3: recombine partial products, floor shift and cap
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq_full[a] = (SQF_W'(s2_sq_hh_q[a]) << (2 * SQL_W)) +
                   (SQF_W'(s2_sq_hl_q[a]) << (SQL_W + 1)) +
                   SQF_W'(s2_sq_ll_q[a]);
      sq_shr[a]  = sq_full[a][SQF_W-1:SQ_SHR];
      ax_full[a] = (AXF_W'(s2_ax_hh_q[a]) << (PL_W + IL_W)) +
                   (AXF_W'(s2_ax_hl_q[a]) << PL_W) +
                   (AXF_W'(s2_ax_lh_q[a]) << IL_W) +
                   AXF_W'(s2_ax_ll_q[a]);
      ax_shr[a]  = ax_full[a][AXF_W-1:AX_SHR];
      ax_sat[a]  = (ax_shr[a] > (AXF_W - AX_SHR)'(TERM_CAP)) ? TERM_W'(TERM_CAP)
                                                             : ax_shr[a][TERM_W-1:0];
    end
  end

  // stage 6: a term
  always_comb begin
    a_full = (AF_W'(s5_ahi_q) << RL_W) + AF_W'(s5_alo_q);
    a_shr  = a_full[AF_W-1:A_SHR];
  end

  // stage 7: total and its magnitude
  always_comb begin
    total   = s6_ax_q + $signed(TOT_W'(s6_a_q));
    total_n = -total;
  end

  // stage 9: final scale, sign and saturation
  always_comb begin
    f_full = (FF_W'(s8_hh_q) << (ML_W + DL_W)) +
             (FF_W'(s8_hl_q) << ML_W) +
             (FF_W'(s8_lh_q) << DL_W) +
             FF_W'(s8_ll_q);
    f_r    = f_full[FF_W-1:D_SHR];
    if (s8_neg_q) begin
      nv_d = (f_r > NEG_LIM) ? NV_MIN : ({VAL_W{1'b0}} - f_r[VAL_W-1:0]);
    end else begin
      nv_d = (f_r > POS_LIM) ? NV_MAX : f_r[VAL_W-1:0];
    end
  end

  // output stage: change magnitude, boundary pass-through
  always_comb begin
    diff   = {s9_nv_q[VAL_W-1], s9_nv_q} - {ctr_q[PIPE_DEPTH-2][VAL_W-1], ctr_q[PIPE_DEPTH-2]};
    diff_m = diff[VAL_W] ? ({(VAL_W + 1){1'b0}} - diff) : diff;
    if (bnd_q[PIPE_DEPTH-2]) begin
      new_value_d  = $signed(ctr_q[PIPE_DEPTH-2]);
      abs_change_d = '0;
    end else begin
      new_value_d  = $signed(s9_nv_q);
      abs_change_d = (diff_m[VAL_W:ABS_W] != '0) ? {ABS_W{1'b1}} : diff_m[ABS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bnd_q[0] <= bnd_d;
      ctr_q[0] <= center_value_i;
      for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
        bnd_q[k] <= bnd_q[k-1];
        ctr_q[k] <= ctr_q[k-1];
      end
      for (int a = 0; a < 3; a++) begin
        // stage 1
        s1_sqm_q[a] <= coord[a][SQM_W] ? coord_n[a][SQM_W-1:0] : coord[a][SQM_W-1:0];
        s1_pn_q[a]  <= psum[a][PS_W-1];
        s1_pm_q[a]  <= psum[a][PS_W-1] ? ({PS_W{1'b0}} - psum[a]) : psum[a];
        // stage 2
        s2_sq_hh_q[a] <= (2*SQH_W)'(s1_sqm_q[a][SQM_W-1:SQL_W]) *
                         (2*SQH_W)'(s1_sqm_q[a][SQM_W-1:SQL_W]);
        s2_sq_hl_q[a] <= (SQH_W+SQL_W)'(s1_sqm_q[a][SQM_W-1:SQL_W]) *
                         (SQH_W+SQL_W)'(s1_sqm_q[a][SQL_W-1:0]);
        s2_sq_ll_q[a] <= (2*SQL_W)'(s1_sqm_q[a][SQL_W-1:0]) *
                         (2*SQL_W)'(s1_sqm_q[a][SQL_W-1:0]);
        s2_ax_hh_q[a] <= (PH_W+IH_W)'(s1_pm_q[a][PS_W-1:PL_W]) *
                         (PH_W+IH_W)'(inv[a][INV_W-1:IL_W]);
        s2_ax_hl_q[a] <= (PH_W+IL_W)'(s1_pm_q[a][PS_W-1:PL_W]) *
                         (PH_W+IL_W)'(inv[a][IL_W-1:0]);
        s2_ax_lh_q[a] <= (PL_W+IH_W)'(s1_pm_q[a][PL_W-1:0]) *
                         (PL_W+IH_W)'(inv[a][INV_W-1:IL_W]);
        s2_ax_ll_q[a] <= (PL_W+IL_W)'(s1_pm_q[a][PL_W-1:0]) *
                         (PL_W+IL_W)'(inv[a][IL_W-1:0]);
        s2_pn_q[a]    <= s1_pn_q[a];
        // stage 3
        s3_sq_q[a] <= (sq_shr[a] > (SQF_W - SQ_SHR)'(TERM_CAP)) ? TERM_W'(TERM_CAP)
                                                               : sq_shr[a][TERM_W-1:0];
        s3_at_q[a] <= s2_pn_q[a] ? $signed({AT_W{1'b0}} - {1'b0, ax_sat[a]})
                                 : $signed({1'b0, ax_sat[a]});
      end
      // stage 4
      s4_r2_q <= R2_W'(s3_sq_q[0]) + R2_W'(s3_sq_q[1]) + R2_W'(s3_sq_q[2]);
      s4_ax_q <= TOT_W'(s3_at_q[0]) + TOT_W'(s3_at_q[1]) + TOT_W'(s3_at_q[2]) - SIX_Q32;
      // stage 5
      s5_alo_q <= (COEF_W+RL_W)'(cfg_i.coef_a) * (COEF_W+RL_W)'(s4_r2_q[RL_W-1:0]);
      s5_ahi_q <= (COEF_W+RH_W)'(cfg_i.coef_a) * (COEF_W+RH_W)'(s4_r2_q[R2_W-1:RL_W]);
      s5_ax_q  <= s4_ax_q;
      // stage 6
      s6_a_q  <= (a_shr > (AF_W - A_SHR)'(TERM_CAP)) ? TERM_W'(TERM_CAP)
                                                     : a_shr[TERM_W-1:0];
      s6_ax_q <= s5_ax_q;
      // stage 7
      s7_neg_q <= total[TOT_W-1];
      s7_mag_q <= total[TOT_W-1] ? total_n[MAG_W-1:0] : total[MAG_W-1:0];
      // stage 8
      s8_hh_q  <= (MH_W+DH_W)'(s7_mag_q[MAG_W-1:ML_W]) *
                  (MH_W+DH_W)'(cfg_i.diag_recip[DIAG_W-1:DL_W]);
      s8_hl_q  <= (MH_W+DL_W)'(s7_mag_q[MAG_W-1:ML_W]) *
                  (MH_W+DL_W)'(cfg_i.diag_recip[DL_W-1:0]);
      s8_lh_q  <= (ML_W+DH_W)'(s7_mag_q[ML_W-1:0]) *
                  (ML_W+DH_W)'(cfg_i.diag_recip[DIAG_W-1:DL_W]);
      s8_ll_q  <= (ML_W+DL_W)'(s7_mag_q[ML_W-1:0]) *
                  (ML_W+DL_W)'(cfg_i.diag_recip[DL_W-1:0]);
      s8_neg_q <= s7_neg_q;
      // stage 9
      s9_nv_q <= nv_d;
      // output register
      new_value_q   <= new_value_d;
      abs_change_q  <= abs_change_d;
      on_boundary_q <= bnd_q[PIPE_DEPTH-2];
    end
  end

  assign valid_o       = valid_q[PIPE_DEPTH-1];
  assign new_value_o   = new_value_q;
  assign abs_change_o  = abs_change_q;
  assign on_boundary_o = on_boundary_q;

endmodule

// File: src/jacobi_stencil_point_update_core.sv
// One Jacobi update of a 3-D Helmholtz-type equation on a 7-point stencil, one
// grid point per word. A point whose index is 0 or at/above GRID-1 on any axis
// passes through (new_value_o = center, abs_change_o = 0, on_boundary_o = 1).
// Interior points get diag_recip * (pair sums * inv_h2 per axis - 6 +
// coef_a * (x^2 + y^2 + z^2)), with coordinate = -1.0 + index * step; point
// values in Q8.32 fixed point, truncated toward zero and saturated to 40 bits;
// abs_change_o is |new - center| saturated to 39 bits. Rate: one word per clock
// while the output word is taken or the output register is empty. The datapath
// has ten register stages (coordinate, split products, recombine, radius sum, a
// term products, a term, total, scale products, scale and saturate, output
// register). The pipeline moves as a whole: while the output register holds a
// word that is not taken, all stages hold and in_ready_o is low. Configuration
// registers (index on cfg_index_i, data on cfg_data_i, low bits used):
// 0 coef_a, 1 diag_recip, 2..4 inv_hx2/hy2/hz2, 5..7 step_x/y/z; other indices
// are ignored. Write them only while no word is in flight.
module jacobi_stencil_point_update_core import jspu_pkg::*; #(
  parameter int unsigned GRID_X = GRID_X_DEFAULT,
  parameter int unsigned GRID_Y = GRID_Y_DEFAULT,
  parameter int unsigned GRID_Z = GRID_Z_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // input word
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VAL_W-1:0] center_value_i,
  input  logic signed [VAL_W-1:0] west_value_i,
  input  logic signed [VAL_W-1:0] east_value_i,
  input  logic signed [VAL_W-1:0] south_value_i,
  input  logic signed [VAL_W-1:0] north_value_i,
  input  logic signed [VAL_W-1:0] below_value_i,
  input  logic signed [VAL_W-1:0] above_value_i,
  input  logic [IDX_W-1:0]        x_index_i,
  input  logic [IDX_W-1:0]        y_index_i,
  input  logic [IDX_W-1:0]        z_index_i,
  // output word
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] new_value_o,
  output logic [ABS_W-1:0]        abs_change_o,
  output logic                    on_boundary_o
);

  jspu_cfg_t cfg_q;
  jspu_cfg_t cfg_d;
  logic      pipe_en;

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  // register file write decode, out-of-range index leaves everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_A:     cfg_d.coef_a     = cfg_data_i[COEF_W-1:0];
        REG_DIAG_RECIP: cfg_d.diag_recip = cfg_data_i[DIAG_W-1:0];
        REG_INV_HX2:    cfg_d.inv_hx2    = cfg_data_i[INV_W-1:0];
        REG_INV_HY2:    cfg_d.inv_hy2    = cfg_data_i[INV_W-1:0];
        REG_INV_HZ2:    cfg_d.inv_hz2    = cfg_data_i[INV_W-1:0];
        REG_STEP_X:     cfg_d.step_x     = cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:     cfg_d.step_y     = cfg_data_i[STEP_W-1:0];
        REG_STEP_Z:     cfg_d.step_z     = cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        coef_a:     COEF_A_RST,
        diag_recip: DIAG_RST,
        inv_hx2:    INV_H2_RST,
        inv_hy2:    INV_H2_RST,
        inv_hz2:    INV_H2_RST,
        step_x:     STEP_RST,
        step_y:     STEP_RST,
        step_z:     STEP_RST
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // whole pipeline advances unless the output word is waiting
  assign pipe_en    = !out_valid_o || out_ready_i;
  assign in_ready_o = pipe_en;

  jspu_datapath #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (pipe_en),
    .valid_i        (in_valid_i),
    .cfg_i          (cfg_q),
    .center_value_i (center_value_i),
    .west_value_i   (west_value_i),
    .east_value_i   (east_value_i),
    .south_value_i  (south_value_i),
    .north_value_i  (north_value_i),
    .below_value_i  (below_value_i),
    .above_value_i  (above_value_i),
    .x_index_i      (x_index_i),
    .y_index_i      (y_index_i),
    .z_index_i      (z_index_i),
    .valid_o        (out_valid_o),
    .new_value_o    (new_value_o),
    .abs_change_o   (abs_change_o),
    .on_boundary_o  (on_boundary_o)
  );

  // pass-through points never report a change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_boundary_o |-> abs_change_o == '0)
    else $error("boundary word with nonzero change");

  // an empty output register must never block the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // no word can come out right after reset release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output word right after reset");

endmodule
